// ===== rtl/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and state helpers of the ChaCha20 keystream block.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned STATE_WORDS   = 16;
    localparam int unsigned DOUBLE_ROUNDS = 10;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 64;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] t_state;
    typedef logic [3:0][CFG_DATA_W-1:0] t_key;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HIGH = 3'd5;

    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    function automatic t_state build_init(
        input t_key                  key,
        input logic [CFG_DATA_W-1:0] nonce_low,
        input t_word                 nonce_high,
        input t_word                 counter
    );
        t_state w;
        w[0] = SIGMA_0;
        w[1] = SIGMA_1;
        w[2] = SIGMA_2;
        w[3] = SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            w[4'(4 + 2 * i)] = key[2'(i)][31:0];
            w[4'(5 + 2 * i)] = key[2'(i)][63:32];
        end
        w[12] = counter;
        w[13] = nonce_low[31:0];
        w[14] = nonce_low[63:32];
        w[15] = nonce_high;
        return w;
    endfunction

    // Row r is rotated left by r words, so a diagonal round becomes a column round.
    function automatic t_state diag_in(input t_state x);
        t_state p;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                p[4'(4 * r + c)] = x[4'(4 * r + ((c + r) & 3))];
            end
        end
        return p;
    endfunction

    function automatic t_state diag_out(input t_state q);
        t_state y;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                y[4'(4 * r + ((c + r) & 3))] = q[4'(4 * r + c)];
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/chacha20_keystream_block.sv =====
// ----------------------------------------------------------------------------
// chacha20_keystream_block
// ChaCha20 block function: one counter in, sixteen keystream words out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_stall      i_block_counter
// output    out        o_valid / i_stall      o_keystream_word, o_word_index, o_last_word
// config    in         i_cfg_we               i_cfg_idx, i_cfg_data
//
// The rounds run in a pipeline of 4 * DOUBLE_ROUNDS register stages, half a
// column or diagonal round each, followed by the output register.
// A request passes the round stages in order and then loads the output register
// with its first word; sustained, the request rate is set by the output, which
// sends a single word per cycle while i_stall is low.
// The whole pipeline holds while a finished block waits for the output
// register, and o_stall is then high. Reset clears all valid bits and the key
// and nonce registers.
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_keystream_block #(
    parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [cc20_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [cc20_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [31:0]                         i_block_counter,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [31:0]                         o_keystream_word,
    output logic [3:0]                          o_word_index,
    output logic                                o_last_word
);

    localparam int unsigned NUM_ROUNDS = 2 * DOUBLE_ROUNDS;

    cc20_pkg::t_key               r_key;
    logic [cc20_pkg::CFG_DATA_W-1:0] r_nonce_low;
    cc20_pkg::t_word              r_nonce_high;

    cc20_pkg::t_state w_state [NUM_ROUNDS+1];
    cc20_pkg::t_word  w_ctr   [NUM_ROUNDS+1];
    logic             w_vld   [NUM_ROUNDS+1];
    cc20_pkg::t_state w_init_fin;
    logic             w_en;
    logic             w_ser_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_nonce_low  <= '0;
            r_nonce_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cc20_pkg::CFG_KEY_0:      r_key[0]     <= i_cfg_data;
                cc20_pkg::CFG_KEY_1:      r_key[1]     <= i_cfg_data;
                cc20_pkg::CFG_KEY_2:      r_key[2]     <= i_cfg_data;
                cc20_pkg::CFG_KEY_3:      r_key[3]     <= i_cfg_data;
                cc20_pkg::CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                cc20_pkg::CFG_NONCE_HIGH: r_nonce_high <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign w_en    = !w_vld[NUM_ROUNDS] || w_ser_ready;
    assign o_stall = !w_en;

    assign w_state[0] = cc20_pkg::build_init(r_key, r_nonce_low, r_nonce_high,
                                             i_block_counter);
    assign w_ctr[0]   = i_block_counter;
    assign w_vld[0]   = i_valid;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        cc20_pkg::t_state w_in;
        cc20_pkg::t_state w_out;

        if (g % 2 == 0) begin : g_column
            assign w_in           = w_state[g];
            assign w_state[g + 1] = w_out;
        end else begin : g_diagonal
            assign w_in           = cc20_pkg::diag_in(w_state[g]);
            assign w_state[g + 1] = cc20_pkg::diag_out(w_out);
        end

        cc20_round_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[g]),
            .i_state (w_in),
            .i_ctr   (w_ctr[g]),
            .o_valid (w_vld[g + 1]),
            .o_state (w_out),
            .o_ctr   (w_ctr[g + 1])
        );
    end

    assign w_init_fin = cc20_pkg::build_init(r_key, r_nonce_low, r_nonce_high,
                                             w_ctr[NUM_ROUNDS]);

    cc20_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_vld[NUM_ROUNDS]),
        .i_work  (w_state[NUM_ROUNDS]),
        .i_init  (w_init_fin),
        .o_ready (w_ser_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_keystream_word),
        .o_index (o_word_index),
        .o_last  (o_last_word)
    );

endmodule

`default_nettype wire

// ===== rtl/cc20_round_stage.sv =====
// ----------------------------------------------------------------------------
// cc20_round_stage
// One column round of four quarter-rounds, split over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_round_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  cc20_pkg::t_state    i_state,
    input  cc20_pkg::t_word     i_ctr,
    output logic                o_valid,
    output cc20_pkg::t_state    o_state,
    output cc20_pkg::t_word     o_ctr
);

    function automatic cc20_pkg::t_word rotl(input cc20_pkg::t_word x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    cc20_pkg::t_state n_mid;
    cc20_pkg::t_state n_out;
    cc20_pkg::t_state r_mid;
    cc20_pkg::t_state r_out;
    cc20_pkg::t_word  r_mid_ctr;
    cc20_pkg::t_word  r_out_ctr;
    logic             r_mid_valid;
    logic             r_out_valid;

    always_comb begin
        cc20_pkg::t_word a;
        cc20_pkg::t_word b;
        cc20_pkg::t_word c;
        cc20_pkg::t_word d;
        n_mid = i_state;
        for (int k = 0; k < 4; k++) begin
            a = i_state[4'(k)];
            b = i_state[4'(4 + k)];
            c = i_state[4'(8 + k)];
            d = i_state[4'(12 + k)];
            a = a + b;
            d = rotl(d ^ a, 16);
            c = c + d;
            b = rotl(b ^ c, 12);
            n_mid[4'(k)]      = a;
            n_mid[4'(4 + k)]  = b;
            n_mid[4'(8 + k)]  = c;
            n_mid[4'(12 + k)] = d;
        end
    end

    always_comb begin
        cc20_pkg::t_word a;
        cc20_pkg::t_word b;
        cc20_pkg::t_word c;
        cc20_pkg::t_word d;
        n_out = r_mid;
        for (int k = 0; k < 4; k++) begin
            a = r_mid[4'(k)];
            b = r_mid[4'(4 + k)];
            c = r_mid[4'(8 + k)];
            d = r_mid[4'(12 + k)];
            a = a + b;
            d = rotl(d ^ a, 8);
            c = c + d;
            b = rotl(b ^ c, 7);
            n_out[4'(k)]      = a;
            n_out[4'(4 + k)]  = b;
            n_out[4'(8 + k)]  = c;
            n_out[4'(12 + k)] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_mid_valid <= i_valid;
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid     <= n_mid;
            r_mid_ctr <= i_ctr;
            r_out     <= n_out;
            r_out_ctr <= r_mid_ctr;
        end
    end

    assign o_valid = r_out_valid;
    assign o_state = r_out;
    assign o_ctr   = r_out_ctr;

endmodule

`default_nettype wire

// ===== rtl/cc20_serializer.sv =====
// ----------------------------------------------------------------------------
// cc20_serializer
// Adds the initial state back and sends the sixteen words out one by one.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_serializer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  cc20_pkg::t_state    i_work,
    input  cc20_pkg::t_state    i_init,
    output logic                o_ready,
    output logic                o_valid,
    input  wire                 i_stall,
    output cc20_pkg::t_word     o_word,
    output logic [3:0]          o_index,
    output logic                o_last
);

    cc20_pkg::t_state r_blk;
    cc20_pkg::t_state n_blk;
    logic [3:0]       r_idx;
    logic             r_busy;
    logic             w_load;
    logic             w_last;

    assign w_last  = (r_idx == 4'd15);
    assign o_ready = !r_busy || (w_last && !i_stall);
    assign w_load  = i_valid && o_ready;

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            n_blk[4'(k)] = i_work[4'(k)] + i_init[4'(k)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= 4'd0;
        end else if (r_busy && !i_stall) begin
            r_busy <= !w_last;
            r_idx  <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_busy;
    assign o_word  = r_blk[r_idx];
    assign o_index = r_idx;
    assign o_last  = w_last;

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid && o_index == 4'($past(o_index) + 4'd1))
        else $error("word index did not advance by one");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid && o_index == 4'd0)
        else $error("new block did not start at word zero");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !i_stall && !i_valid |=> !o_valid)
        else $error("output still valid after the last word");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("idle serializer refused a block");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the ChaCha20 keystream block. A directed table
// covers the counter and key extremes, ignored register writes and dropped
// register bits, then random counters under several key settings run while
// the sender and the receiver idle and stall at random. Every keystream word
// is checked against a block function computed in the testbench, and some first words against published values.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROUND_PAIRS     = 10;
    localparam int WORDS           = 16;
    localparam int RESET_CYCLES    = 11;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 54;
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 2 * ROUND_PAIRS + 10;
    localparam int CYCLE_LIMIT     = 200000;

    typedef logic [cc20_pkg::CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [cc20_pkg::CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_IDX_SPARE_A = 3'd6;
    localparam t_cfg_idx CFG_IDX_SPARE_B = 3'd7;

    typedef enum logic { ROW_WRITE, ROW_BLOCK } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        t_cfg_idx               idx;
        t_cfg_data              data;
        cc20_pkg::t_word        counter;
        logic                   pinned;
        cc20_pkg::t_word        word0;
    } t_dir_row;

    typedef struct packed {
        cc20_pkg::t_word word;
        logic [3:0]      index;
        logic            last;
    } t_ks_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_idx = '0;
    t_cfg_data             i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [31:0]           i_block_counter = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [31:0]           o_keystream_word;
    logic [3:0]            o_word_index;
    logic                  o_last_word;

    t_cfg_data             key_reg [4];
    t_cfg_data             nonce_lo_reg;
    cc20_pkg::t_word       nonce_hi_reg;

    t_ks_word keystream_q [$];
    t_dir_row dir_rows [$];
    int       mismatch_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_trigger = 0;
    int       hold_seen = 0;
    int       hold_left = 0;

    chacha20_keystream_block dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_block_counter  (i_block_counter),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_keystream_word (o_keystream_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic cc20_pkg::t_word rotl(input cc20_pkg::t_word v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic cc20_pkg::t_state mix_quarter(input cc20_pkg::t_state s,
                                                     input int a, input int b,
                                                     input int c, input int d);
        s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 7);
        return s;
    endfunction

    function automatic cc20_pkg::t_state keystream_block(input cc20_pkg::t_word counter);
        cc20_pkg::t_state init;
        cc20_pkg::t_state work;
        init[0] = cc20_pkg::SIGMA_0;
        init[1] = cc20_pkg::SIGMA_1;
        init[2] = cc20_pkg::SIGMA_2;
        init[3] = cc20_pkg::SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            init[4 + 2 * i] = key_reg[i][31:0];
            init[5 + 2 * i] = key_reg[i][63:32];
        end
        init[12] = counter;
        init[13] = nonce_lo_reg[31:0];
        init[14] = nonce_lo_reg[63:32];
        init[15] = nonce_hi_reg;
        work = init;
        for (int r = 0; r < ROUND_PAIRS; r++) begin
            work = mix_quarter(work, 0, 4, 8, 12);
            work = mix_quarter(work, 1, 5, 9, 13);
            work = mix_quarter(work, 2, 6, 10, 14);
            work = mix_quarter(work, 3, 7, 11, 15);
            work = mix_quarter(work, 0, 5, 10, 15);
            work = mix_quarter(work, 1, 6, 11, 12);
            work = mix_quarter(work, 2, 7, 8, 13);
            work = mix_quarter(work, 3, 4, 9, 14);
        end
        for (int i = 0; i < WORDS; i++) begin
            work[i] = work[i] + init[i];
        end
        return work;
    endfunction

    function automatic cc20_pkg::t_word pick_counter();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) return cc20_pkg::t_word'($urandom_range(3));
        if (roll == 1) return 32'hFFFF_FFFF - cc20_pkg::t_word'($urandom_range(3));
        return $urandom;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cc20_pkg::CFG_KEY_0:      key_reg[0] = data;
            cc20_pkg::CFG_KEY_1:      key_reg[1] = data;
            cc20_pkg::CFG_KEY_2:      key_reg[2] = data;
            cc20_pkg::CFG_KEY_3:      key_reg[3] = data;
            cc20_pkg::CFG_NONCE_LOW:  nonce_lo_reg = data;
            cc20_pkg::CFG_NONCE_HIGH: nonce_hi_reg = data[31:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_block(input cc20_pkg::t_word counter, input logic pinned,
                              input cc20_pkg::t_word word0);
        cc20_pkg::t_state blk;
        t_ks_word         entry;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid         <= 1'b1;
        i_block_counter <= counter;
        do @(posedge i_clk); while (o_stall);
        blk = keystream_block(counter);
        for (int i = 0; i < WORDS; i++) begin
            entry.word  = (pinned && i == 0) ? word0 : blk[i];
            entry.index = 4'(i);
            entry.last  = (i == WORDS - 1);
            keystream_q.push_back(entry);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (keystream_q.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_phase_keys(input int phase);
        t_cfg_data v;
        for (int r = 0; r <= int'(cc20_pkg::CFG_NONCE_HIGH); r++) begin
            if (phase == 1) v = '1;
            else if (phase == 4) v = '0;
            else v = {$urandom, $urandom};
            write_reg(t_cfg_idx'(r), v);
        end
        write_reg($urandom_range(1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  {$urandom, $urandom});
    endtask

    always @(negedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch
        t_ks_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (keystream_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h index %0d last %0b",
                         $time, o_keystream_word, o_word_index, o_last_word);
                mismatch_count++;
            end else begin
                want = keystream_q.pop_front();
                if (o_keystream_word !== want.word) begin
                    $display("%0t: keystream_word expected %h, got %h",
                             $time, want.word, o_keystream_word);
                    mismatch_count++;
                end
                if (o_word_index !== want.index) begin
                    $display("%0t: word_index expected %0d, got %0d",
                             $time, want.index, o_word_index);
                    mismatch_count++;
                end
                if (o_last_word !== want.last) begin
                    $display("%0t: last_word expected %0b, got %0b",
                             $time, want.last, o_last_word);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_dir_row row;
        // With an all-zero key and nonce the first words of blocks 0 and 1 are
        // the published zero-key keystream.
        dir_rows.push_back('{ROW_BLOCK, cc20_pkg::CFG_KEY_0, 64'h0, 32'h0000_0000,
                             1'b1, 32'hade0_b876});
        dir_rows.push_back('{ROW_BLOCK, cc20_pkg::CFG_KEY_0, 64'h0, 32'h0000_0001,
                             1'b1, 32'hbee7_079f});
        dir_rows.push_back('{ROW_BLOCK, cc20_pkg::CFG_KEY_0, 64'h0, 32'hFFFF_FFFF,
                             1'b0, 32'h0});
        dir_rows.push_back('{ROW_BLOCK, cc20_pkg::CFG_KEY_0, 64'h0, 32'h8000_0000,
                             1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_KEY_0, '1, 32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_KEY_1, '1, 32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_KEY_2, '1, 32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_KEY_3, '1, 32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_NONCE_LOW, '1, 32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_NONCE_HIGH, '1, 32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_BLOCK, cc20_pkg::CFG_KEY_0, 64'h0, 32'h0000_0000,
                             1'b0, 32'h0});
        dir_rows.push_back('{ROW_BLOCK, cc20_pkg::CFG_KEY_0, 64'h0, 32'hFFFF_FFFF,
                             1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, CFG_IDX_SPARE_A, 64'h0, 32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, CFG_IDX_SPARE_B, 64'h0, 32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_BLOCK, cc20_pkg::CFG_KEY_0, 64'h0, 32'h0000_FFFF,
                             1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_KEY_0, 64'h0706_0504_0302_0100,
                             32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_KEY_1, 64'h0f0e_0d0c_0b0a_0908,
                             32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_KEY_2, 64'h1716_1514_1312_1110,
                             32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_KEY_3, 64'h1f1e_1d1c_1b1a_1918,
                             32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_NONCE_LOW, 64'h4a00_0000_0900_0000,
                             32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_WRITE, cc20_pkg::CFG_NONCE_HIGH, 64'hDEAD_BEEF_0000_0000,
                             32'h0, 1'b0, 32'h0});
        dir_rows.push_back('{ROW_BLOCK, cc20_pkg::CFG_KEY_0, 64'h0, 32'h0000_0001,
                             1'b0, 32'h0});
        dir_rows.push_back('{ROW_BLOCK, cc20_pkg::CFG_KEY_0, 64'h0, 32'h0000_0007,
                             1'b0, 32'h0});

        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        nonce_lo_reg = '0;
        nonce_hi_reg = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.kind == ROW_WRITE) begin
                wait_idle();
                write_reg(row.idx, row.data);
            end else begin
                send_block(row.counter, row.pinned, row.word0);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            load_phase_keys(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 0 && n == 6) hold_trigger++;
                if (p == 2 && n == ITEMS_PER_PHASE / 2) wait_idle();
                send_block(pick_counter(), 1'b0, 32'h0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && keystream_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
